/* rtl/ptt_pkg.sv */
// Shared widths, types and helper functions for the point-in-triangle test.
// Self-contained; every rtl module refers to it by scoped names.
`timescale 1ns / 1ps

package ptt_pkg;

    // Coordinate format and derived widths
    localparam int COORD_W = 16;
    localparam int DIFF_W  = COORD_W + 1;          // a - b of two coordinates
    localparam int MUL_W   = 2 * DIFF_W;           // product of two differences
    localparam int DOT_W   = 2 * DIFF_W + 1;       // sum of three such products
    localparam int LO_W    = (DOT_W + 1) / 2;      // low slice of a split operand
    localparam int HI_W    = DOT_W - LO_W;         // signed high slice
    localparam int PPL_W   = DOT_W + LO_W + 1;     // dot times unsigned low slice
    localparam int PPH_W   = DOT_W + HI_W;         // dot times signed high slice
    localparam int PROD_W  = 2 * DOT_W;            // full product of two dots

    // Four sign tests: the degenerate check and one per edge
    localparam int NUM_PAIR = 4;
    localparam int PAIR_DEG = 0;
    localparam int PAIR_E0  = 1;
    localparam int PAIR_E1  = 2;
    localparam int PAIR_E2  = 3;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]  t_diff;
    typedef logic signed [MUL_W-1:0]   t_mul;
    typedef logic signed [DOT_W-1:0]   t_dot;
    typedef logic signed [PPL_W-1:0]   t_ppl;
    typedef logic signed [PPH_W-1:0]   t_pph;
    typedef logic signed [PROD_W-1:0]  t_prod;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_cvec;

    typedef struct packed {
        t_diff x;
        t_diff y;
        t_diff z;
    } t_dvec;

    typedef struct packed {
        t_mul x;
        t_mul y;
        t_mul z;
    } t_mvec;

    // Per test: s = (x.u)(y.v) - (x.v)(y.u), which equals (x cross y) . (u cross v)
    typedef struct packed {
        t_dot xu;
        t_dot yv;
        t_dot xv;
        t_dot yu;
    } t_dquad;

    typedef struct packed {
        t_mvec xu;
        t_mvec yv;
        t_mvec xv;
        t_mvec yu;
    } t_mquad;

    typedef struct packed {
        t_ppl ab_lo;
        t_pph ab_hi;
        t_ppl cd_lo;
        t_pph cd_hi;
    } t_pquad;

    typedef struct packed {
        t_prod ab;
        t_prod cd;
    } t_tpair;

    // Componentwise difference, exact
    function automatic t_dvec vsub(input t_cvec a, input t_cvec b);
        t_dvec r;
        r.x = t_diff'(a.x) - t_diff'(b.x);
        r.y = t_diff'(a.y) - t_diff'(b.y);
        r.z = t_diff'(a.z) - t_diff'(b.z);
        return r;
    endfunction

    // Componentwise product, exact
    function automatic t_mvec vmul(input t_dvec a, input t_dvec b);
        t_mvec r;
        r.x = t_mul'(a.x) * t_mul'(b.x);
        r.y = t_mul'(a.y) * t_mul'(b.y);
        r.z = t_mul'(a.z) * t_mul'(b.z);
        return r;
    endfunction

    // Sum of the three component products
    function automatic t_dot vsum(input t_mvec m);
        return t_dot'(m.x) + t_dot'(m.y) + t_dot'(m.z);
    endfunction

endpackage

/* rtl/point_in_triangle_test_unit.sv */
// Point-in-triangle prism test, top level: ties the input, dot and sign stages.
// Depends on ptt_pkg, ptt_diff, ptt_dot and ptt_lagr.
//
// Usage:
//   Input channel: i_valid / o_stall with three vertices (a, b, c) and a query
//   point, each coordinate a signed 16-bit fixed-point value. A request is
//   taken at a clock edge with i_valid high and o_stall low.
//   Output channel: o_valid / i_stall with o_inside_res and o_degenerate. A
//   result is taken at an edge with o_valid high and i_stall low.
//   One request is accepted every cycle while o_stall is low; the six
//   register stages (difference, products, sums, split products, recombine,
//   sign test) each hold one.
//   o_degenerate is set when the face normal is zero; o_inside_res is then 0.
//   A point exactly on an edge or corner counts as inside.
//   Reset (i_rst_n low, synchronous) empties every stage; no result is shown.
//   While the receiver stalls, the output holds and earlier stages keep
//   filling any empty slot; o_stall rises only once every stage is occupied.
`timescale 1ns / 1ps

module point_in_triangle_test_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  ptt_pkg::t_coord       i_a_x,
    input  ptt_pkg::t_coord       i_a_y,
    input  ptt_pkg::t_coord       i_a_z,
    input  ptt_pkg::t_coord       i_b_x,
    input  ptt_pkg::t_coord       i_b_y,
    input  ptt_pkg::t_coord       i_b_z,
    input  ptt_pkg::t_coord       i_c_x,
    input  ptt_pkg::t_coord       i_c_y,
    input  ptt_pkg::t_coord       i_c_z,
    input  ptt_pkg::t_coord       i_point_x,
    input  ptt_pkg::t_coord       i_point_y,
    input  ptt_pkg::t_coord       i_point_z,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_inside_res,
    output logic                  o_degenerate
);

    ptt_pkg::t_cvec                           va;
    ptt_pkg::t_cvec                           vb;
    ptt_pkg::t_cvec                           vc;
    ptt_pkg::t_cvec                           vp;
    logic                                     in_ready;
    logic                                     diff_vld;
    logic                                     diff_rdy;
    ptt_pkg::t_dvec                           diff_u;
    ptt_pkg::t_dvec                           diff_v;
    ptt_pkg::t_dvec  [ptt_pkg::NUM_PAIR-1:0]  diff_x;
    ptt_pkg::t_dvec  [ptt_pkg::NUM_PAIR-1:0]  diff_y;
    logic                                     dot_vld;
    logic                                     dot_rdy;
    ptt_pkg::t_dquad [ptt_pkg::NUM_PAIR-1:0]  dot_q;

    // Bundle the coordinates into vectors
    assign va = '{x: i_a_x,     y: i_a_y,     z: i_a_z};
    assign vb = '{x: i_b_x,     y: i_b_y,     z: i_b_z};
    assign vc = '{x: i_c_x,     y: i_c_y,     z: i_c_z};
    assign vp = '{x: i_point_x, y: i_point_y, z: i_point_z};

    assign o_stall = !in_ready;

    ptt_diff u_diff (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (in_ready),
        .i_a     (va),
        .i_b     (vb),
        .i_c     (vc),
        .i_p     (vp),
        .o_valid (diff_vld),
        .i_ready (diff_rdy),
        .o_u     (diff_u),
        .o_v     (diff_v),
        .o_x     (diff_x),
        .o_y     (diff_y)
    );

    ptt_dot u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (diff_vld),
        .o_ready (diff_rdy),
        .i_u     (diff_u),
        .i_v     (diff_v),
        .i_x     (diff_x),
        .i_y     (diff_y),
        .o_valid (dot_vld),
        .i_ready (dot_rdy),
        .o_dot   (dot_q)
    );

    ptt_lagr u_lagr (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (dot_vld),
        .o_ready  (dot_rdy),
        .i_dot    (dot_q),
        .o_valid  (o_valid),
        .i_ready  (!i_stall),
        .o_inside (o_inside_res),
        .o_degen  (o_degenerate)
    );

    // A degenerate triangle never reports inside
    a_degen_not_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_inside_res && o_degenerate))
        else $error("degenerate result reported as inside");

    // Back-pressure reaches the input only when the output is held
    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall && dot_vld && diff_vld))
        else $error("input stalled with a free stage");

    // Reset empties the pipeline
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !dot_vld && !diff_vld)
        else $error("stage valid after reset");

endmodule

/* rtl/ptt_diff.sv */
// Input stage: forms the edge and offset vectors for the four sign tests.
// Depends on ptt_pkg for vector types and the vsub helper.
`timescale 1ns / 1ps

module ptt_diff (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  ptt_pkg::t_cvec                          i_a,
    input  ptt_pkg::t_cvec                          i_b,
    input  ptt_pkg::t_cvec                          i_c,
    input  ptt_pkg::t_cvec                          i_p,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output ptt_pkg::t_dvec                          o_u,
    output ptt_pkg::t_dvec                          o_v,
    output ptt_pkg::t_dvec [ptt_pkg::NUM_PAIR-1:0]  o_x,
    output ptt_pkg::t_dvec [ptt_pkg::NUM_PAIR-1:0]  o_y
);

    logic                                    r_vld;
    ptt_pkg::t_dvec                          r_u;
    ptt_pkg::t_dvec                          r_v;
    ptt_pkg::t_dvec [ptt_pkg::NUM_PAIR-1:0]  r_x;
    ptt_pkg::t_dvec [ptt_pkg::NUM_PAIR-1:0]  r_y;
    ptt_pkg::t_dvec                          n_u;
    ptt_pkg::t_dvec                          n_v;
    ptt_pkg::t_dvec [ptt_pkg::NUM_PAIR-1:0]  n_x;
    ptt_pkg::t_dvec [ptt_pkg::NUM_PAIR-1:0]  n_y;

    // Take a new request whenever this stage is empty or drains this cycle
    assign o_ready = !r_vld || i_ready;

    // Normal spans u and v; each edge pairs its direction with the point offset
    always_comb begin
        n_u = ptt_pkg::vsub(i_b, i_a);
        n_v = ptt_pkg::vsub(i_c, i_a);
        n_x[ptt_pkg::PAIR_DEG] = n_u;
        n_y[ptt_pkg::PAIR_DEG] = n_v;
        n_x[ptt_pkg::PAIR_E0]  = n_u;
        n_y[ptt_pkg::PAIR_E0]  = ptt_pkg::vsub(i_p, i_a);
        n_x[ptt_pkg::PAIR_E1]  = ptt_pkg::vsub(i_c, i_b);
        n_y[ptt_pkg::PAIR_E1]  = ptt_pkg::vsub(i_p, i_b);
        n_x[ptt_pkg::PAIR_E2]  = ptt_pkg::vsub(i_a, i_c);
        n_y[ptt_pkg::PAIR_E2]  = ptt_pkg::vsub(i_p, i_c);
    end

    // Advance the valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    // Capture the vectors of an accepted request, hold otherwise
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_u <= n_u;
            r_v <= n_v;
            r_x <= n_x;
            r_y <= n_y;
        end
    end

    assign o_valid = r_vld;
    assign o_u     = r_u;
    assign o_v     = r_v;
    assign o_x     = r_x;
    assign o_y     = r_y;

endmodule

/* rtl/ptt_dot.sv */
// Two-stage dot product unit: component products, then three-term sums.
// Depends on ptt_pkg for vector types and the vmul and vsum helpers.
`timescale 1ns / 1ps

module ptt_dot (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  ptt_pkg::t_dvec                          i_u,
    input  ptt_pkg::t_dvec                          i_v,
    input  ptt_pkg::t_dvec [ptt_pkg::NUM_PAIR-1:0]  i_x,
    input  ptt_pkg::t_dvec [ptt_pkg::NUM_PAIR-1:0]  i_y,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output ptt_pkg::t_dquad [ptt_pkg::NUM_PAIR-1:0] o_dot
);

    logic                                     r_vld_m;
    logic                                     r_vld_s;
    logic                                     rdy_m;
    logic                                     rdy_s;
    ptt_pkg::t_mquad [ptt_pkg::NUM_PAIR-1:0]  r_mul;
    ptt_pkg::t_mquad [ptt_pkg::NUM_PAIR-1:0]  n_mul;
    ptt_pkg::t_dquad [ptt_pkg::NUM_PAIR-1:0]  r_dot;
    ptt_pkg::t_dquad [ptt_pkg::NUM_PAIR-1:0]  n_dot;

    // Stage readiness, back from the output
    assign rdy_s   = !r_vld_s || i_ready;
    assign rdy_m   = !r_vld_m || rdy_s;
    assign o_ready = rdy_m;

    // Component products for x.u, y.v, x.v and y.u of every test
    always_comb begin
        for (int k = 0; k < ptt_pkg::NUM_PAIR; k++) begin
            n_mul[k].xu = ptt_pkg::vmul(i_x[k], i_u);
            n_mul[k].yv = ptt_pkg::vmul(i_y[k], i_v);
            n_mul[k].xv = ptt_pkg::vmul(i_x[k], i_v);
            n_mul[k].yu = ptt_pkg::vmul(i_y[k], i_u);
        end
    end

    // Reduce the registered products to dot products
    always_comb begin
        for (int k = 0; k < ptt_pkg::NUM_PAIR; k++) begin
            n_dot[k].xu = ptt_pkg::vsum(r_mul[k].xu);
            n_dot[k].yv = ptt_pkg::vsum(r_mul[k].yv);
            n_dot[k].xv = ptt_pkg::vsum(r_mul[k].xv);
            n_dot[k].yu = ptt_pkg::vsum(r_mul[k].yu);
        end
    end

    // Advance the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_m <= 1'b0;
            r_vld_s <= 1'b0;
        end else begin
            if (rdy_m) begin
                r_vld_m <= i_valid;
            end
            if (rdy_s) begin
                r_vld_s <= r_vld_m;
            end
        end
    end

    // Move payload only with a valid request
    always_ff @(posedge i_clk) begin
        if (rdy_m && i_valid) begin
            r_mul <= n_mul;
        end
        if (rdy_s && r_vld_m) begin
            r_dot <= n_dot;
        end
    end

    assign o_valid = r_vld_s;
    assign o_dot   = r_dot;

endmodule

/* rtl/ptt_lagr.sv */
// Sign stages: forms (x.u)(y.v) - (x.v)(y.u) per test from split products,
// then derives the degenerate and inside flags. Depends on ptt_pkg.
`timescale 1ns / 1ps

module ptt_lagr (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  ptt_pkg::t_dquad [ptt_pkg::NUM_PAIR-1:0] i_dot,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic                                    o_inside,
    output logic                                    o_degen
);

    logic                                     r_vld_p;
    logic                                     r_vld_t;
    logic                                     r_vld_f;
    logic                                     rdy_p;
    logic                                     rdy_t;
    logic                                     rdy_f;
    ptt_pkg::t_pquad [ptt_pkg::NUM_PAIR-1:0]  r_pp;
    ptt_pkg::t_pquad [ptt_pkg::NUM_PAIR-1:0]  n_pp;
    ptt_pkg::t_tpair [ptt_pkg::NUM_PAIR-1:0]  r_term;
    ptt_pkg::t_tpair [ptt_pkg::NUM_PAIR-1:0]  n_term;
    ptt_pkg::t_prod  [ptt_pkg::NUM_PAIR-1:0]  sval;
    logic            [ptt_pkg::NUM_PAIR-1:0]  sneg;
    logic                                     n_degen;
    logic                                     n_inside;
    logic                                     r_degen;
    logic                                     r_inside;

    // Stage readiness, back from the output register
    assign rdy_f   = !r_vld_f || i_ready;
    assign rdy_t   = !r_vld_t || rdy_f;
    assign rdy_p   = !r_vld_p || rdy_t;
    assign o_ready = rdy_p;

    // Split the right operand into an unsigned low and a signed high slice
    always_comb begin
        for (int k = 0; k < ptt_pkg::NUM_PAIR; k++) begin
            n_pp[k].ab_lo = ptt_pkg::t_ppl'(i_dot[k].xu)
                * ptt_pkg::t_ppl'($signed({1'b0, i_dot[k].yv[ptt_pkg::LO_W-1:0]}));
            n_pp[k].ab_hi = ptt_pkg::t_pph'(i_dot[k].xu)
                * ptt_pkg::t_pph'($signed(i_dot[k].yv[ptt_pkg::DOT_W-1:ptt_pkg::LO_W]));
            n_pp[k].cd_lo = ptt_pkg::t_ppl'(i_dot[k].xv)
                * ptt_pkg::t_ppl'($signed({1'b0, i_dot[k].yu[ptt_pkg::LO_W-1:0]}));
            n_pp[k].cd_hi = ptt_pkg::t_pph'(i_dot[k].xv)
                * ptt_pkg::t_pph'($signed(i_dot[k].yu[ptt_pkg::DOT_W-1:ptt_pkg::LO_W]));
        end
    end

    // Recombine the partial products into the two full terms
    always_comb begin
        for (int k = 0; k < ptt_pkg::NUM_PAIR; k++) begin
            n_term[k].ab = (ptt_pkg::t_prod'(r_pp[k].ab_hi) <<< ptt_pkg::LO_W)
                         + ptt_pkg::t_prod'(r_pp[k].ab_lo);
            n_term[k].cd = (ptt_pkg::t_prod'(r_pp[k].cd_hi) <<< ptt_pkg::LO_W)
                         + ptt_pkg::t_prod'(r_pp[k].cd_lo);
        end
    end

    // Subtract, then test signs; a zero squared normal length means degenerate
    always_comb begin
        for (int k = 0; k < ptt_pkg::NUM_PAIR; k++) begin
            sval[k] = r_term[k].ab - r_term[k].cd;
            sneg[k] = sval[k][ptt_pkg::PROD_W-1];
        end
        n_degen  = (sval[ptt_pkg::PAIR_DEG] == '0);
        n_inside = !n_degen && !sneg[ptt_pkg::PAIR_E0]
                 && !sneg[ptt_pkg::PAIR_E1] && !sneg[ptt_pkg::PAIR_E2];
    end

    // Advance the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_p <= 1'b0;
            r_vld_t <= 1'b0;
            r_vld_f <= 1'b0;
        end else begin
            if (rdy_p) begin
                r_vld_p <= i_valid;
            end
            if (rdy_t) begin
                r_vld_t <= r_vld_p;
            end
            if (rdy_f) begin
                r_vld_f <= r_vld_t;
            end
        end
    end

    // Move payload only with a valid request; the flag register is the output
    always_ff @(posedge i_clk) begin
        if (rdy_p && i_valid) begin
            r_pp <= n_pp;
        end
        if (rdy_t && r_vld_p) begin
            r_term <= n_term;
        end
        if (rdy_f && r_vld_t) begin
            r_degen  <= n_degen;
            r_inside <= n_inside;
        end
    end

    assign o_valid  = r_vld_f;
    assign o_inside = r_inside;
    assign o_degen  = r_degen;

endmodule

/* bench/point_in_triangle_test_unit_tb.sv */
// Self-checking bench for point_in_triangle_test_unit: exact prism-test predictor,
// directed corner cases, then shaped random queries under random idling.
// Depends on ptt_pkg and the rtl top level only.
`timescale 1ns / 1ps

module point_in_triangle_test_unit_tb;

    // Wide enough that no cross or dot term can overflow at 16-bit coordinates
    typedef logic signed [127:0] t_exact;

    typedef struct {
        t_exact x;
        t_exact y;
        t_exact z;
    } t_evec;

    typedef struct {
        ptt_pkg::t_cvec a;
        ptt_pkg::t_cvec b;
        ptt_pkg::t_cvec c;
        ptt_pkg::t_cvec p;
    } t_query;

    typedef struct {
        bit inside_res;
        bit degenerate;
    } t_verdict;

    typedef enum {
        Q_FULL,
        Q_INNER,
        Q_EDGE,
        Q_DEGEN,
        Q_TINY,
        Q_EXTREME
    } t_shape;

    // Prism-test predictor and the queue of verdicts still owed by the block
    class prism_scoreboard;
        t_verdict verdict_q[$];
        int       mismatches;

        function new();
            mismatches = 0;
        endfunction

        function t_evec offset(ptt_pkg::t_cvec u, ptt_pkg::t_cvec v);
            t_evec r;
            r.x = t_exact'($signed(u.x)) - t_exact'($signed(v.x));
            r.y = t_exact'($signed(u.y)) - t_exact'($signed(v.y));
            r.z = t_exact'($signed(u.z)) - t_exact'($signed(v.z));
            return r;
        endfunction

        function t_evec xprod(t_evec u, t_evec v);
            t_evec r;
            r.x = u.y * v.z - u.z * v.y;
            r.y = u.z * v.x - u.x * v.z;
            r.z = u.x * v.y - u.y * v.x;
            return r;
        endfunction

        function t_exact dot(t_evec u, t_evec v);
            return u.x * v.x + u.y * v.y + u.z * v.z;
        endfunction

        function t_verdict judge(t_query q);
            t_evec    e0;
            t_evec    e1;
            t_evec    e2;
            t_evec    nrm;
            t_exact   s0;
            t_exact   s1;
            t_exact   s2;
            t_verdict v;
            e0  = offset(q.b, q.a);
            e1  = offset(q.c, q.b);
            e2  = offset(q.a, q.c);
            nrm = xprod(e0, offset(q.c, q.a));
            s0  = dot(xprod(e0, offset(q.p, q.a)), nrm);
            s1  = dot(xprod(e1, offset(q.p, q.b)), nrm);
            s2  = dot(xprod(e2, offset(q.p, q.c)), nrm);
            v.degenerate = (nrm.x == 0) && (nrm.y == 0) && (nrm.z == 0);
            v.inside_res = !v.degenerate && (s0 >= 0) && (s1 >= 0) && (s2 >= 0);
            return v;
        endfunction

        function void note_request(t_query q);
            verdict_q.insert(verdict_q.size(), judge(q));
        endfunction

        function void check_verdict(logic inside_res, logic degenerate);
            t_verdict want;
            if (verdict_q.size() == 0) begin
                $error("result with no request outstanding: inside_res %0b degenerate %0b",
                       inside_res, degenerate);
                mismatches++;
                return;
            end
            want = verdict_q.pop_front();
            if (inside_res !== want.inside_res) begin
                $error("inside_res: expected %0b, got %0b", want.inside_res, inside_res);
                mismatches++;
            end
            if (degenerate !== want.degenerate) begin
                $error("degenerate: expected %0b, got %0b", want.degenerate, degenerate);
                mismatches++;
            end
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction
    endclass

    logic            i_clk;
    logic            i_rst_n;
    logic            i_valid;
    logic            o_stall;
    ptt_pkg::t_coord i_a_x, i_a_y, i_a_z;
    ptt_pkg::t_coord i_b_x, i_b_y, i_b_z;
    ptt_pkg::t_coord i_c_x, i_c_y, i_c_z;
    ptt_pkg::t_coord i_point_x, i_point_y, i_point_z;
    logic            o_valid;
    logic            i_stall;
    logic            o_inside_res;
    logic            o_degenerate;

    prism_scoreboard board;
    bit              hold_off_go = 1'b0;

    point_in_triangle_test_unit i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_a_x        (i_a_x),
        .i_a_y        (i_a_y),
        .i_a_z        (i_a_z),
        .i_b_x        (i_b_x),
        .i_b_y        (i_b_y),
        .i_b_z        (i_b_z),
        .i_c_x        (i_c_x),
        .i_c_y        (i_c_y),
        .i_c_z        (i_c_z),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_point_z    (i_point_z),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_inside_res (o_inside_res),
        .o_degenerate (o_degenerate)
    );

    // Free-running clock, 2 ns period
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("point_in_triangle_test_unit_tb: FAIL");
        $finish;
    end

    function automatic int rnd(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic int sat(int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic ptt_pkg::t_cvec cv(int x, int y, int z);
        ptt_pkg::t_cvec r;
        r.x = ptt_pkg::t_coord'(x);
        r.y = ptt_pkg::t_coord'(y);
        r.z = ptt_pkg::t_coord'(z);
        return r;
    endfunction

    function automatic ptt_pkg::t_cvec rvec(int lo, int hi);
        return cv(rnd(lo, hi), rnd(lo, hi), rnd(lo, hi));
    endfunction

    // base + m * dir, kept inside the coordinate range by construction
    function automatic ptt_pkg::t_cvec along(ptt_pkg::t_cvec base, ptt_pkg::t_cvec dir,
                                             int m);
        return cv(int'(base.x) + m * int'(dir.x),
                  int'(base.y) + m * int'(dir.y),
                  int'(base.z) + m * int'(dir.z));
    endfunction

    function automatic int xpick();
        int edges[7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};
        return edges[rnd(0, 6)];
    endfunction

    function automatic t_query make_query(t_shape shape);
        t_query         q;
        ptt_pkg::t_cvec d;
        ptt_pkg::t_cvec t;
        int             w0, w1, w2, sw, n;
        case (shape)
            Q_FULL: begin
                q.a = ptt_pkg::t_cvec'({$urandom, $urandom});
                q.b = ptt_pkg::t_cvec'({$urandom, $urandom});
                q.c = ptt_pkg::t_cvec'({$urandom, $urandom});
                q.p = ptt_pkg::t_cvec'({$urandom, $urandom});
            end
            Q_INNER: begin
                // convex combination of the corners, nudged off the plane
                q.a = rvec(-32768, 32767);
                q.b = rvec(-32768, 32767);
                q.c = rvec(-32768, 32767);
                w0  = rnd(0, 255);
                w1  = rnd(0, 255);
                w2  = rnd(0, 255);
                sw  = w0 + w1 + w2;
                if (sw == 0) begin
                    w0 = 1;
                    sw = 1;
                end
                q.p = cv(sat((w0 * int'(q.a.x) + w1 * int'(q.b.x) + w2 * int'(q.c.x)) / sw
                             + rnd(-200, 200)),
                         sat((w0 * int'(q.a.y) + w1 * int'(q.b.y) + w2 * int'(q.c.y)) / sw
                             + rnd(-200, 200)),
                         sat((w0 * int'(q.a.z) + w1 * int'(q.b.z) + w2 * int'(q.c.z)) / sw
                             + rnd(-200, 200)));
            end
            Q_EDGE: begin
                // point exactly on edge a-b, then rotate which edge that is
                q.a = rvec(-10000, 10000);
                d   = rvec(-64, 64);
                n   = rnd(1, 200);
                q.b = along(q.a, d, n);
                q.c = rvec(-32768, 32767);
                q.p = along(q.a, d, rnd(0, n));
                case (rnd(0, 2))
                    1: begin
                        t = q.a; q.a = q.b; q.b = q.c; q.c = t;
                    end
                    2: begin
                        t = q.a; q.a = q.c; q.c = q.b; q.b = t;
                    end
                    default: ;
                endcase
            end
            Q_DEGEN: begin
                // collinear corners; a zero direction makes them coincide
                q.a = rvec(-10000, 10000);
                d   = (rnd(0, 7) == 0) ? cv(0, 0, 0) : rvec(-64, 64);
                q.b = along(q.a, d, rnd(-100, 100));
                q.c = along(q.a, d, rnd(-100, 100));
                q.p = (rnd(0, 1) == 0) ? along(q.a, d, rnd(-100, 100)) : rvec(-32768, 32767);
            end
            Q_TINY: begin
                q.a = rvec(-3, 3);
                q.b = rvec(-3, 3);
                q.c = rvec(-3, 3);
                q.p = rvec(-3, 3);
            end
            default: begin
                q.a = cv(xpick(), xpick(), xpick());
                q.b = cv(xpick(), xpick(), xpick());
                q.c = cv(xpick(), xpick(), xpick());
                q.p = cv(xpick(), xpick(), xpick());
            end
        endcase
        return q;
    endfunction

    // Present one request from the falling edge and hold it until taken
    task automatic offer(ptt_pkg::t_cvec a, ptt_pkg::t_cvec b,
                         ptt_pkg::t_cvec c, ptt_pkg::t_cvec p);
        t_query q;
        q.a = a;
        q.b = b;
        q.c = c;
        q.p = p;
        @(negedge i_clk);
        i_valid   <= 1'b1;
        i_a_x     <= a.x;
        i_a_y     <= a.y;
        i_a_z     <= a.z;
        i_b_x     <= b.x;
        i_b_y     <= b.y;
        i_b_z     <= b.z;
        i_c_x     <= c.x;
        i_c_y     <= c.y;
        i_c_z     <= c.z;
        i_point_x <= p.x;
        i_point_y <= p.y;
        i_point_z <= p.z;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.note_request(q);
    endtask

    task automatic idle(int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
    endtask

    task automatic wait_drained();
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    // Check every result the block hands over
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            board.check_verdict(o_inside_res, o_degenerate);
    end

    // Receiver: stretches of random stall density, plus one long hold-off on request
    initial begin
        int run_len;
        int mode;
        int hold_left;
        i_stall   = 1'b0;
        run_len   = 0;
        mode      = 0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (hold_off_go) begin
                hold_off_go = 1'b0;
                hold_left   = 59;
                i_stall    <= 1'b1;
            end else begin
                if (run_len == 0) begin
                    run_len = rnd(1, 40);
                    mode    = rnd(0, 3);
                end
                run_len--;
                case (mode)
                    0:       i_stall <= 1'b0;
                    1:       i_stall <= ($urandom_range(3) == 0);
                    2:       i_stall <= ($urandom_range(3) != 0);
                    default: i_stall <= ~i_stall;
                endcase
            end
        end
    end

    // Sender and run control
    initial begin
        t_query q;
        int     burst_left;
        int     r;
        int     guard;
        board      = new();
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_a_x      = '0;
        i_a_y      = '0;
        i_a_z      = '0;
        i_b_x      = '0;
        i_b_y      = '0;
        i_b_z      = '0;
        i_c_x      = '0;
        i_c_y      = '0;
        i_c_z      = '0;
        i_point_x  = '0;
        i_point_y  = '0;
        i_point_z  = '0;
        burst_left = 0;

        // Hold reset, then release it from a falling edge
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Degenerate: all corners coincide, at zero and both extremes
        offer(cv(0, 0, 0), cv(0, 0, 0), cv(0, 0, 0), cv(0, 0, 0));
        offer(cv(32767, 32767, 32767), cv(32767, 32767, 32767),
              cv(32767, 32767, 32767), cv(32767, 32767, 32767));
        offer(cv(-32768, -32768, -32768), cv(-32768, -32768, -32768),
              cv(-32768, -32768, -32768), cv(-32768, -32768, -32768));
        // Right triangle in z = 0: inside, off-plane, on an edge, on a corner, outside
        offer(cv(0, 0, 0), cv(100, 0, 0), cv(0, 100, 0), cv(10, 10, 0));
        offer(cv(0, 0, 0), cv(100, 0, 0), cv(0, 100, 0), cv(10, 10, 5000));
        offer(cv(0, 0, 0), cv(100, 0, 0), cv(0, 100, 0), cv(50, 50, 0));
        offer(cv(0, 0, 0), cv(100, 0, 0), cv(0, 100, 0), cv(0, 0, 0));
        offer(cv(0, 0, 0), cv(100, 0, 0), cv(0, 100, 0), cv(100, 0, -32768));
        idle(3);
        offer(cv(0, 0, 0), cv(100, 0, 0), cv(0, 100, 0), cv(60, 60, 0));
        offer(cv(0, 0, 0), cv(100, 0, 0), cv(0, 100, 0), cv(-1, 10, 0));
        // Reversed winding
        offer(cv(0, 0, 0), cv(0, 100, 0), cv(100, 0, 0), cv(10, 10, 0));
        // Full-range triangle, points at corners and extremes
        offer(cv(-32768, -32768, -32768), cv(32767, -32768, 32767),
              cv(-32768, 32767, 32767), cv(-32768, -32768, -32768));
        offer(cv(-32768, -32768, -32768), cv(32767, -32768, 32767),
              cv(-32768, 32767, 32767), cv(32767, 32767, -32768));
        offer(cv(-32768, -32768, -32768), cv(32767, -32768, 32767),
              cv(-32768, 32767, 32767), cv(0, 0, 0));
        offer(cv(-32768, -32768, -32768), cv(32767, -32768, 32767),
              cv(-32768, 32767, 32767), cv(32767, 32767, 32767));
        // Collinear, coincident and half-coincident corners
        offer(cv(0, 0, 0), cv(1, 1, 1), cv(2, 2, 2), cv(1, 1, 1));
        offer(cv(-5, 7, 9), cv(-5, 7, 9), cv(-5, 7, 9), cv(-5, 7, 9));
        offer(cv(3, -4, 5), cv(3, -4, 5), cv(-300, 200, 100), cv(0, 0, 0));
        // Triangle in a plane of constant x, point far off the plane
        offer(cv(5, 0, 0), cv(5, 32767, 0), cv(5, 0, 32767), cv(-32768, 1, 1));
        // Mixed-sign extremes, point on edge a-c
        offer(cv(32767, -32768, 0), cv(-32768, 32767, 0), cv(32767, 32767, 0),
              cv(32767, 0, 0));

        // Sender pauses until every result is back
        idle(1);
        wait_drained();

        // Long receiver hold-off while requests keep coming back to back
        hold_off_go = 1'b1;
        repeat (40) begin
            q = make_query(Q_INNER);
            offer(q.a, q.b, q.c, q.p);
        end

        // Random queries in bursts with random gaps
        for (int i = 0; i < 1090; i++) begin
            if (burst_left == 0) begin
                burst_left = ($urandom_range(9) == 0) ? 150 : rnd(1, 24);
                idle(rnd(1, 10));
            end
            if (i == 545) begin
                idle(1);
                wait_drained();
            end
            r = rnd(0, 99);
            if (r < 30)      q = make_query(Q_FULL);
            else if (r < 55) q = make_query(Q_INNER);
            else if (r < 72) q = make_query(Q_EDGE);
            else if (r < 82) q = make_query(Q_DEGEN);
            else if (r < 92) q = make_query(Q_TINY);
            else             q = make_query(Q_EXTREME);
            offer(q.a, q.b, q.c, q.p);
            burst_left--;
        end
        idle(1);

        // Drain, then allow for the pipeline latency to catch stray results
        guard = 0;
        while (board.pending() != 0 && guard < 50000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (12) @(posedge i_clk);
        if (board.pending() != 0) begin
            $error("%0d results never arrived", board.pending());
            board.mismatches++;
        end

        if (board.mismatches == 0) begin
            $display("point_in_triangle_test_unit_tb: PASS");
        end else begin
            $display("point_in_triangle_test_unit_tb: FAIL");
        end
        $finish;
    end

endmodule
